### rtl/lrec_pkg.sv
package lrec_pkg;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int RGB_W      = 24;

  // input kinds carried on s_tuser
  localparam logic [1:0] MODE_APPLY  = 2'd0;
  localparam logic [1:0] MODE_EXTERN = 2'd1;
  localparam logic [1:0] MODE_ALARM  = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [2:0] EXPR_NEUTRAL   = 3'd0;
  localparam logic [2:0] EXPR_INDICATOR = 3'd1;
  localparam logic [2:0] EXPR_LIGHTING  = 3'd2;
  localparam logic [2:0] EXPR_SMILE     = 3'd3;
  localparam logic [2:0] EXPR_SAD       = 3'd4;
  localparam logic [2:0] EXPR_ALARM     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ALARM_BLINK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IND_BLINK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_ALARM  = 2'd2;

  localparam logic [15:0] ALARM_BLINK_RST = 16'd500;
  localparam logic [15:0] IND_BLINK_RST   = 16'd1000;
  localparam logic [31:0] LONG_ALARM_RST  = 32'd10000;

  localparam logic [RGB_W-1:0] COLOR_BLACK  = 24'h000000;
  localparam logic [RGB_W-1:0] COLOR_GREEN  = 24'h00A000;
  localparam logic [RGB_W-1:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [RGB_W-1:0] COLOR_RED    = 24'hFF0000;
  localparam logic [RGB_W-1:0] COLOR_ORANGE = 24'hC86400;

  // how a redraw changes each stored pixel
  typedef enum logic [2:0] {
    OP_DRAW,
    OP_RED,
    OP_RED0,
    OP_CLR0,
    OP_BLACK,
    OP_CLR6
  } op_t;

  typedef struct packed {
    logic             forced;
    logic             ext;
    logic [2:0]       expr;
    logic             last;
    logic [RGB_W-1:0] rgb;
    logic [3:0]       idx;
  } pix_t;

endpackage

### rtl/lrec_ram.sv
module lrec_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/led_ring_expression_controller_unit.sv
// channel  | direction | fields
// s_axis   | in        | tuser: mode; tdata: expression_code, timeout_ms, extern_enable,
//          |           |   now_ms, urgency_active, urgency_since_ms
// m_axis   | out       | tlast: last_pixel; tdata: pixel_index, red, green, blue,
//          |           |   expression_now, extern_now, alarm_forced
// cfg      | in        | cfg_index selects the register, cfg_data the value
//
// an item is accepted, then evaluated, and, when it redraws, every pixel is redrawn:
// the pixel ram is read once per pixel through its one read port and written back
// as the data returns, one pixel per cycle while m_tready stays high
// reset is synchronous; the pixel ram has no reset, a valid bit per pixel makes an
// unwritten pixel read as the neutral pattern
// an output register and a skid stage absorb m_tready stalls; reads pause while two pixels wait
module led_ring_expression_controller_unit #(
  parameter int PIXELS    = 12,
  parameter int TIME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // expression_code, timeout_ms, extern_enable, now_ms, urgency_active, urgency_since_ms
  input  logic [lrec_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pixel_index, red, green, blue, expression_now, extern_now, alarm_forced
  output logic [lrec_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [lrec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lrec_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lrec_pkg::*;

  localparam int KW = $clog2(PIXELS);
  localparam int IW = $clog2(PIXELS + 1);
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RUN
  } state_t;

  state_t state;

  logic [15:0] alarm_blink_ms;
  logic [15:0] indicator_blink_ms;
  logic [31:0] long_alarm_ms;

  logic [1:0]           in_mode;
  logic [2:0]           in_code;
  logic [TIME_BITS-1:0] in_timeout;
  logic                 in_en;
  logic [TIME_BITS-1:0] in_now;
  logic                 in_urg;
  logic [TIME_BITS-1:0] in_since;

  logic [2:0]           expression_reg;
  logic                 extern_flag;
  logic                 forced_flag;
  logic [TIME_BITS-1:0] expire_time;
  logic                 blink_phase;
  logic [TIME_BITS-1:0] last_toggle_time;
  op_t                  op;

  logic [2:0]           expression_next;
  logic                 extern_next;
  logic                 forced_next;
  logic [TIME_BITS-1:0] expire_next;
  logic                 phase_next;
  logic [TIME_BITS-1:0] toggle_next;
  op_t                  op_next;
  logic                 frame_next;

  logic [TIME_BITS-1:0] dt_toggle;
  logic [TIME_BITS-1:0] dt_urg;
  logic                 alarm_due;
  logic                 ind_due;
  logic                 long_urg;
  logic                 expired;

  logic [IW-1:0]        rd_idx;
  logic [KW-1:0]        rd_k;
  logic                 rd_pend;
  logic [1:0]           occ;
  logic                 take;
  logic                 issue;

  logic [PIXELS-1:0]    pix_valid;
  logic [RGB_W-1:0]     ram_rdata;
  logic [RGB_W-1:0]     old_px;
  logic [RGB_W-1:0]     new_px;
  pix_t                 arr_px;
  pix_t                 out_q;
  pix_t                 skid_q;
  logic                 out_valid;
  logic                 skid_valid;
  logic                 arr_to_out;
  logic                 arr_to_skid;

  function automatic logic [RGB_W-1:0] pattern_px(input logic [2:0] e, input logic [KW-1:0] k);
    logic [RGB_W-1:0] c;
    c = COLOR_BLACK;
    case (e)
      EXPR_INDICATOR: c = (k == KW'(6)) ? COLOR_GREEN : COLOR_BLACK;
      EXPR_LIGHTING:  c = COLOR_WHITE;
      EXPR_SMILE:     c = (k inside {[4:8]}) ? COLOR_GREEN : COLOR_BLACK;
      EXPR_SAD:       c = (k inside {[0:2], 10, 11}) ? COLOR_ORANGE : COLOR_BLACK;
      EXPR_ALARM:     c = COLOR_RED;
      default:        c = (k inside {[5:7]}) ? COLOR_GREEN : COLOR_BLACK;
    endcase
    return c;
  endfunction

  assign s_tready = (state == ST_IDLE) && !rst;

  // decision for the captured item
  assign dt_toggle = in_now - last_toggle_time;
  assign dt_urg    = in_now - in_since;
  assign alarm_due = CW'(dt_toggle) >= CW'(alarm_blink_ms);
  assign ind_due   = CW'(dt_toggle) >= CW'(indicator_blink_ms);
  assign long_urg  = in_urg && (CW'(dt_urg) > CW'(long_alarm_ms));
  assign expired   = (expire_time != '0) && (in_now >= expire_time);

  always_comb begin
    expression_next = expression_reg;
    extern_next     = extern_flag;
    forced_next     = forced_flag;
    expire_next     = expire_time;
    phase_next      = blink_phase;
    toggle_next     = last_toggle_time;
    op_next         = OP_DRAW;
    frame_next      = 1'b0;
    case (in_mode)
      MODE_APPLY: begin
        if (!forced_flag) begin
          extern_next     = 1'b0;
          expression_next = (in_code <= EXPR_ALARM) ? in_code : EXPR_NEUTRAL;
          expire_next     = (in_timeout != '0) ? in_now + in_timeout : '0;
          phase_next      = 1'b1;
          toggle_next     = in_now;
          frame_next      = 1'b1;
        end
      end
      MODE_EXTERN: begin
        if (!forced_flag) begin
          extern_next = in_en;
        end
      end
      MODE_ALARM: begin
        forced_next     = 1'b1;
        expression_next = EXPR_ALARM;
        phase_next      = 1'b1;
        toggle_next     = in_now;
        op_next         = OP_RED;
        frame_next      = 1'b1;
      end
      default: begin
        if (!forced_flag && expired) begin
          extern_next     = 1'b0;
          expression_next = EXPR_NEUTRAL;
          expire_next     = '0;
          phase_next      = 1'b1;
          toggle_next     = in_now;
          frame_next      = 1'b1;
        end else if (forced_flag || expression_reg == EXPR_ALARM) begin
          if (alarm_due) begin
            phase_next  = !blink_phase;
            toggle_next = in_now;
            frame_next  = 1'b1;
            if (!blink_phase) begin
              op_next = long_urg ? OP_RED0 : OP_RED;
            end else begin
              op_next = long_urg ? OP_CLR0 : OP_BLACK;
            end
          end
        end else if (!extern_flag && expression_reg == EXPR_INDICATOR && ind_due) begin
          phase_next  = !blink_phase;
          toggle_next = in_now;
          frame_next  = 1'b1;
          op_next     = blink_phase ? OP_CLR6 : OP_DRAW;
        end
      end
    endcase
  end

  // read side: at most two pixels in flight across ram output, output register and skid
  assign take  = out_valid && m_tready;
  assign occ   = {1'b0, out_valid} + {1'b0, skid_valid} + {1'b0, rd_pend};
  assign issue = (state == ST_RUN) && (rd_idx < IW'(PIXELS)) && ((occ - {1'b0, take}) < 2'd2);

  assign old_px = pix_valid[rd_k] ? ram_rdata : pattern_px(EXPR_NEUTRAL, rd_k);

  always_comb begin
    case (op)
      OP_DRAW:  new_px = pattern_px(expression_reg, rd_k);
      OP_RED:   new_px = COLOR_RED;
      OP_RED0:  new_px = (rd_k == '0) ? COLOR_RED : COLOR_BLACK;
      OP_CLR0:  new_px = (rd_k == '0) ? COLOR_BLACK : old_px;
      OP_BLACK: new_px = COLOR_BLACK;
      OP_CLR6:  new_px = (rd_k == KW'(6)) ? COLOR_BLACK : old_px;
      default:  new_px = old_px;
    endcase
  end

  always_comb begin
    arr_px.forced = forced_flag;
    arr_px.ext    = extern_flag;
    arr_px.expr   = expression_reg;
    arr_px.last   = (rd_k == KW'(PIXELS - 1));
    arr_px.rgb    = new_px;
    arr_px.idx    = rd_k[3:0];
  end

  assign arr_to_out  = rd_pend && !skid_valid && (!out_valid || take);
  assign arr_to_skid = rd_pend && !arr_to_out;

  lrec_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PIXELS)
  ) u_pix_ram (
    .clk  (clk),
    .we   (rd_pend),
    .waddr(rd_k),
    .wdata(new_px),
    .re   (issue),
    .raddr(rd_idx[KW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      alarm_blink_ms     <= ALARM_BLINK_RST;
      indicator_blink_ms <= IND_BLINK_RST;
      long_alarm_ms      <= LONG_ALARM_RST;
      expression_reg     <= EXPR_NEUTRAL;
      extern_flag        <= 1'b0;
      forced_flag        <= 1'b0;
      expire_time        <= '0;
      blink_phase        <= 1'b0;
      last_toggle_time   <= '0;
      op                 <= OP_DRAW;
      rd_idx             <= '0;
      rd_pend            <= 1'b0;
      pix_valid          <= '0;
      out_valid          <= 1'b0;
      skid_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ALARM_BLINK: alarm_blink_ms     <= cfg_data[15:0];
          REG_IND_BLINK:   indicator_blink_ms <= cfg_data[15:0];
          REG_LONG_ALARM:  long_alarm_ms      <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          expression_reg   <= expression_next;
          extern_flag      <= extern_next;
          forced_flag      <= forced_next;
          expire_time      <= expire_next;
          blink_phase      <= phase_next;
          last_toggle_time <= toggle_next;
          op               <= op_next;
          rd_idx           <= '0;
          state            <= frame_next ? ST_RUN : ST_IDLE;
        end
        ST_RUN: begin
          if (rd_idx == IW'(PIXELS) && !rd_pend) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      rd_pend <= issue;
      if (rd_pend) begin
        pix_valid[rd_k] <= 1'b1;
      end
      out_valid  <= arr_to_out || (skid_valid && take) || (out_valid && !take);
      skid_valid <= arr_to_skid || (skid_valid && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      in_mode    <= s_tuser;
      in_code    <= s_tdata[2:0];
      in_timeout <= TIME_BITS'(s_tdata[34:3]);
      in_en      <= s_tdata[35];
      in_now     <= TIME_BITS'(s_tdata[67:36]);
      in_urg     <= s_tdata[68];
      in_since   <= TIME_BITS'(s_tdata[100:69]);
    end
    if (issue) begin
      rd_k <= rd_idx[KW-1:0];
    end
    if (skid_valid && take) begin
      out_q <= skid_q;
    end else if (arr_to_out) begin
      out_q <= arr_px;
    end
    if (arr_to_skid) begin
      skid_q <= arr_px;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_q.last;
  assign m_tdata  = {7'd0, out_q.forced, out_q.ext, out_q.expr, out_q.rgb[7:0],
                     out_q.rgb[15:8], out_q.rgb[23:16], out_q.idx};

endmodule

### rtl/lrec_checker.sv
module lrec_checker #(
  parameter int PIXELS = 12
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lrec_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tlast
);

  import lrec_pkg::*;

  localparam int KW = $clog2(PIXELS);

  logic [KW-1:0] exp_idx;
  logic          seen_forced;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx     <= '0;
      seen_forced <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      exp_idx <= m_tlast ? '0 : exp_idx + 1'b1;
      if (m_tdata[32]) begin
        seen_forced <= 1'b1;
      end
    end
  end

  a_in_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready again right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_pixel_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] == exp_idx[3:0]) && (m_tlast == (exp_idx == KW'(PIXELS - 1))))
    else $error("pixel index or tlast out of frame order");

  a_forced_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_forced |-> m_tdata[32])
    else $error("alarm latch dropped without reset");

  a_forced_expr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[30:28] == EXPR_ALARM)
    else $error("alarm latched but expression is not alarm");

endmodule

bind led_ring_expression_controller_unit lrec_checker #(
  .PIXELS(PIXELS)
) u_lrec_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
